// ===== rtl/tss_pkg.sv =====
// Shared types and constants for the two-stack shared-memory block.
// No dependencies; every other file but tss_ram refers to this package by scoped name.
package tss_pkg;

  localparam int VALUE_W            = 32;
  localparam int COUNT_W            = 7;
  localparam int DEF_DEPTH          = 64;
  localparam int DEF_DATA_WIDTH     = 32;

  typedef enum logic [1:0] {
    MODE_PUSH_ONE = 2'd0,
    MODE_PUSH_TWO = 2'd1,
    MODE_POP_ONE  = 2'd2,
    MODE_POP_TWO  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUSH_ONE,
    ACT_PUSH_TWO,
    ACT_POP_ONE,
    ACT_POP_TWO
  } act_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    act_t    op;
    logic    fetch_one;
    logic    fetch_two;
    logic    status_we;
    status_t status;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty_one;
    logic  empty_two;
    logic  low_one;
    logic  low_two;
  } dp_stat_t;

endpackage

// ===== rtl/tss_if.sv =====
// Valid/ready channel interfaces for the operation and result streams.
// Depends on tss_pkg for field widths.
interface tss_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         mode;
  logic signed [tss_pkg::VALUE_W-1:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface tss_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [tss_pkg::VALUE_W-1:0] top_one;
  logic signed [tss_pkg::VALUE_W-1:0] top_two;
  logic [tss_pkg::COUNT_W-1:0]        count_one;
  logic [tss_pkg::COUNT_W-1:0]        count_two;

  modport source (output valid, output status, output top_one, output top_two,
                  output count_one, output count_two, input ready);
  modport sink   (input valid, input status, input top_one, input top_two,
                  input count_one, input count_two, output ready);
endinterface

// ===== rtl/tss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/tss_dp.sv =====
// Datapath: stack depths, cached top values, operation latch and status.
// Depends on tss_pkg and tss_ram.
module tss_dp #(
  parameter int DEPTH      = tss_pkg::DEF_DEPTH,
  parameter int DATA_WIDTH = tss_pkg::DEF_DATA_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tss_pkg::dp_cmd_t                   cmd,
  output tss_pkg::dp_stat_t                  stat,
  input  tss_pkg::mode_t                     in_mode,
  input  logic signed [tss_pkg::VALUE_W-1:0] in_value,
  output logic [1:0]                         status,
  output logic signed [tss_pkg::VALUE_W-1:0] top_one,
  output logic signed [tss_pkg::VALUE_W-1:0] top_two,
  output logic [tss_pkg::COUNT_W-1:0]        count_one,
  output logic [tss_pkg::COUNT_W-1:0]        count_two
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]         depth_one, depth_two;
  logic [DATA_WIDTH-1:0] top_one_r, top_two_r;
  tss_pkg::mode_t        mode_r;
  logic [DATA_WIDTH-1:0] value_r;
  tss_pkg::status_t      status_r;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  assign stat.mode      = mode_r;
  assign stat.full      = (depth_one + depth_two) == CW'(DEPTH);
  assign stat.empty_one = depth_one == '0;
  assign stat.empty_two = depth_two == '0;
  assign stat.low_one   = depth_one < CW'(2);
  assign stat.low_two   = depth_two < CW'(2);

  // Pops read the entry that becomes the new top; with one entry left nothing is read.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = AW'(depth_one);
    mem_raddr = AW'(depth_one - CW'(2));
    unique case (cmd.op)
      tss_pkg::ACT_PUSH_ONE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(depth_one);
      end
      tss_pkg::ACT_PUSH_TWO: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(CW'(DEPTH - 1) - depth_two);
      end
      tss_pkg::ACT_POP_ONE: begin
        mem_re    = !stat.low_one;
        mem_raddr = AW'(depth_one - CW'(2));
      end
      tss_pkg::ACT_POP_TWO: begin
        mem_re    = !stat.low_two;
        mem_raddr = AW'(CW'(DEPTH) - depth_two + CW'(1));
      end
      default: begin
      end
    endcase
  end

  tss_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(value_r),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_one <= '0;
      depth_two <= '0;
    end else begin
      unique case (cmd.op)
        tss_pkg::ACT_PUSH_ONE: depth_one <= depth_one + CW'(1);
        tss_pkg::ACT_PUSH_TWO: depth_two <= depth_two + CW'(1);
        tss_pkg::ACT_POP_ONE:  depth_one <= depth_one - CW'(1);
        tss_pkg::ACT_POP_TWO:  depth_two <= depth_two - CW'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      value_r <= DATA_WIDTH'(in_value);
    end
    if (cmd.status_we) begin
      status_r <= cmd.status;
    end
    if (cmd.op == tss_pkg::ACT_PUSH_ONE) begin
      top_one_r <= value_r;
    end else if (cmd.fetch_one) begin
      top_one_r <= mem_rdata;
    end
    if (cmd.op == tss_pkg::ACT_PUSH_TWO) begin
      top_two_r <= value_r;
    end else if (cmd.fetch_two) begin
      top_two_r <= mem_rdata;
    end
  end

  assign status    = status_r;
  assign top_one   = stat.empty_one ? '0 : tss_pkg::VALUE_W'(top_one_r);
  assign top_two   = stat.empty_two ? '0 : tss_pkg::VALUE_W'(top_two_r);
  assign count_one = tss_pkg::COUNT_W'(depth_one);
  assign count_two = tss_pkg::COUNT_W'(depth_two);

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    (CW + 1)'(depth_one) + (CW + 1)'(depth_two) <= (CW + 1)'(DEPTH))
    else $error("stack depths exceed memory size");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == tss_pkg::ACT_PUSH_ONE || cmd.op == tss_pkg::ACT_PUSH_TWO) |-> !stat.full)
    else $error("push issued with memory full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == tss_pkg::ACT_POP_ONE && stat.empty_one == 1'b0) ||
    (cmd.op == tss_pkg::ACT_POP_TWO && stat.empty_two == 1'b0) ||
    (cmd.op != tss_pkg::ACT_POP_ONE && cmd.op != tss_pkg::ACT_POP_TWO))
    else $error("pop issued on empty stack");

  a_fetch_after_read: assert property (@(posedge clk) disable iff (rst)
    (cmd.fetch_one || cmd.fetch_two) |-> $past(mem_re))
    else $error("top fetched without a preceding read");
`endif

endmodule

// ===== rtl/tss_ctrl.sv =====
// Controller: sequences accept, execute, top fetch and result transfer.
// Depends on tss_pkg.
module tss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tss_pkg::dp_stat_t stat,
  output tss_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_RESP
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd            = '0;
    cmd.op         = tss_pkg::ACT_NONE;
    cmd.status     = tss_pkg::ST_DONE;
    cmd.load       = in_valid && in_ready;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.status_we = 1'b1;
        state_next    = S_RESP;
        unique case (stat.mode)
          tss_pkg::MODE_PUSH_ONE: begin
            if (stat.full) cmd.status = tss_pkg::ST_FULL;
            else           cmd.op     = tss_pkg::ACT_PUSH_ONE;
          end
          tss_pkg::MODE_PUSH_TWO: begin
            if (stat.full) cmd.status = tss_pkg::ST_FULL;
            else           cmd.op     = tss_pkg::ACT_PUSH_TWO;
          end
          tss_pkg::MODE_POP_ONE: begin
            if (stat.empty_one) begin
              cmd.status = tss_pkg::ST_EMPTY;
            end else begin
              cmd.op = tss_pkg::ACT_POP_ONE;
              if (!stat.low_one) state_next = S_FETCH;
            end
          end
          tss_pkg::MODE_POP_TWO: begin
            if (stat.empty_two) begin
              cmd.status = tss_pkg::ST_EMPTY;
            end else begin
              cmd.op = tss_pkg::ACT_POP_TWO;
              if (!stat.low_two) state_next = S_FETCH;
            end
          end
          default: begin
          end
        endcase
      end
      S_FETCH: begin
        cmd.fetch_one = stat.mode == tss_pkg::MODE_POP_ONE;
        cmd.fetch_two = stat.mode == tss_pkg::MODE_POP_TWO;
        state_next    = S_RESP;
      end
      S_RESP: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      in_ready  <= state_next == S_IDLE;
      out_valid <= state_next == S_RESP;
    end
  end

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("operation accepted while a result is pending");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && state_next == S_RESP) |=> out_valid)
    else $error("result not presented after execution");

  a_resp_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before transfer");
`endif

endmodule

// ===== rtl/two_stacks_shared_memory.sv =====
// Two LIFO stacks in one shared memory: stack one grows up from entry 0,
// stack two grows down from the last entry.
//
// Channels: req (sink) carries one operation per transfer: mode selects
// push one, push two, pop one or pop two; push_value is stored by pushes.
// rsp (source) returns exactly one result per operation: status (done,
// full, empty), the top value of each stack (0 when empty) and both counts.
// A push when the stacks meet is refused as full; a pop of an empty stack
// is refused as empty; refused operations change nothing.
//
// The result follows the execute state, or the execute and fetch states for
// a pop of a stack holding two or more entries, which reads the new top back
// from the memory through its registered read port. One operation is in flight
// at a time: a new req is accepted only once the result has transferred.
// While rsp.ready is low the result holds and req.ready stays low.
// Reset clears both stacks; memory contents are not cleared, and entries are
// only read after being pushed.
module two_stacks_shared_memory #(
  parameter int DEPTH      = tss_pkg::DEF_DEPTH,
  parameter int DATA_WIDTH = tss_pkg::DEF_DATA_WIDTH
) (
  input logic         clk,
  input logic         rst,
  tss_req_if.sink     req,
  tss_rsp_if.source   rsp
);

  tss_pkg::dp_cmd_t  cmd;
  tss_pkg::dp_stat_t stat;

  tss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tss_dp #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_mode  (tss_pkg::mode_t'(req.mode)),
    .in_value (req.push_value),
    .status   (rsp.status),
    .top_one  (rsp.top_one),
    .top_two  (rsp.top_two),
    .count_one(rsp.count_one),
    .count_two(rsp.count_two)
  );

endmodule
